// ===== rtl/icp_normal_equation_accumulator_defines.svh =====
// ----------------------------------------------------------------------------
// icp normal equation accumulator assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef ICP_NORMAL_EQUATION_ACCUMULATOR_DEFINES_SVH
`define ICP_NORMAL_EQUATION_ACCUMULATOR_DEFINES_SVH

// same-cycle implication
`define NEA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nea assertion failed");

// next-cycle implication
`define NEA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nea assertion failed");

`endif

// ===== rtl/nea_pkg.sv =====
// ----------------------------------------------------------------------------
// nea_pkg
// types, constants and helpers of the icp normal equation accumulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nea_pkg;

  localparam int unsigned NumHess    = 21;
  localparam int unsigned NumEntries = 27;
  localparam logic [16:0] OneQ16     = 17'h10000;
  localparam logic [4:0]  LastEntryIdx = 5'(NumEntries - 1);

  typedef enum logic {
    REG_LAMBDA    = 1'b0,
    REG_THRESHOLD = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_HUBER,
    ST_SQRT,
    ST_DIV,
    ST_WEIGHT,
    ST_ENTRY,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    logic signed [31:0] src_x;
    logic signed [31:0] src_y;
    logic signed [31:0] src_z;
    logic signed [31:0] tgt_x;
    logic signed [31:0] tgt_y;
    logic signed [31:0] tgt_z;
    logic               pair_kind;
    logic               last_pair;
  } in_pair_t;

  typedef struct packed {
    logic [4:0]         entry_index;
    logic signed [63:0] entry_value;
    logic               last_entry;
  } out_entry_t;

  // classified item between front and back
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [32:0] rx;
    logic signed [32:0] ry;
    logic signed [32:0] rz;
    logic [16:0]        kind_w;
    logic               last;
  } pair_work_t;

  function automatic logic signed [32:0] r_sel(logic [1:0] row, pair_work_t w);
    logic signed [32:0] v;
    unique case (row)
      2'd0:    v = w.rx;
      2'd1:    v = w.ry;
      2'd2:    v = w.rz;
      default: v = '0;
    endcase
    return v;
  endfunction

  // jacobian element [I | skew(src)^T]
  function automatic logic signed [32:0] jac_elem(logic [1:0] row, logic [2:0] col,
                                                  pair_work_t w, logic signed [32:0] one);
    logic signed [32:0] px;
    logic signed [32:0] py;
    logic signed [32:0] pz;
    logic signed [32:0] v;
    px = {w.px[31], w.px};
    py = {w.py[31], w.py};
    pz = {w.pz[31], w.pz};
    v  = '0;
    unique case (col)
      3'd0, 3'd1, 3'd2: v = (row == col[1:0]) ? one : '0;
      3'd3: v = (row == 2'd1) ? -pz : ((row == 2'd2) ? py : '0);
      3'd4: v = (row == 2'd0) ? pz : ((row == 2'd2) ? -px : '0);
      3'd5: v = (row == 2'd0) ? -py : ((row == 2'd1) ? px : '0);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [63:0] sat64(logic signed [85:0] v);
    logic signed [63:0] r;
    if ((&v[85:63]) || !(|v[85:63])) begin
      r = v[63:0];
    end else if (v[85]) begin
      r = {1'b1, 63'b0};
    end else begin
      r = {1'b0, {63{1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== rtl/nea_front.sv =====
// ----------------------------------------------------------------------------
// nea_front
// accepts point pairs, forms residual and kind weight, two-entry queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nea_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  nea_pkg::in_pair_t    pair_i,
  output logic                 full_o,
  input  logic [16:0]          lambda_i,
  output logic                 head_valid_o,
  output nea_pkg::pair_work_t  head_o,
  input  logic                 head_pop_i
);

  nea_pkg::pair_work_t work;
  nea_pkg::pair_work_t mem_q [2];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          cnt_q, cnt_d;
  logic [16:0]         lam;
  logic                wr_en;
  logic                rd_en;

  always_comb begin
    lam         = (lambda_i > nea_pkg::OneQ16) ? nea_pkg::OneQ16 : lambda_i;
    work.px     = pair_i.src_x;
    work.py     = pair_i.src_y;
    work.pz     = pair_i.src_z;
    work.rx     = {pair_i.tgt_x[31], pair_i.tgt_x} - {pair_i.src_x[31], pair_i.src_x};
    work.ry     = {pair_i.tgt_y[31], pair_i.tgt_y} - {pair_i.src_y[31], pair_i.src_y};
    work.rz     = {pair_i.tgt_z[31], pair_i.tgt_z} - {pair_i.src_z[31], pair_i.src_z};
    work.kind_w = pair_i.pair_kind ? lam : nea_pkg::OneQ16 - lam;
    work.last   = pair_i.last_pair;
  end

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];
  assign wr_en        = push_i && !full_o;
  assign rd_en        = head_pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_en ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= work;
    end
  end

endmodule

// ===== rtl/nea_back.sv =====
// ----------------------------------------------------------------------------
// nea_back
// huber weight by iterative sqrt and divide, sequenced entry accumulation
// over a shared multiplier, and emission of the sums
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nea_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  nea_pkg::pair_work_t  head_i,
  output logic                 head_pop_o,
  input  logic [31:0]          thr_i,
  input  logic                 pop_i,
  output logic                 empty_o,
  output nea_pkg::out_entry_t  entry_o
);

  localparam int unsigned       OutShift = 2 * FRAC_BITS - 16;
  localparam logic signed [32:0] JacOne  = 33'(1) << FRAC_BITS;
  localparam logic [4:0]        GradBase = 5'(nea_pkg::NumHess);
  localparam logic [2:0]        ColGrad  = 3'd6;
  localparam logic [2:0]        ColLast  = 3'd5;
  localparam logic [2:0]        StepSum  = 3'd3;
  localparam logic [2:0]        StepScl  = 3'd4;
  localparam logic [2:0]        StepAcc  = 3'd5;
  localparam logic [4:0]        DivInit  = 5'd17;

  nea_pkg::back_state_e state_q, state_d;

  logic [2:0]          step_q;
  logic [2:0]          col_i_q;
  logic [2:0]          col_j_q;
  logic [4:0]          hidx_q;
  logic [4:0]          em_q;
  logic [4:0]          dcnt_q;
  logic signed [65:0]  prod_q;
  logic signed [67:0]  sum_q;
  logic signed [85:0]  scl_q;
  logic [63:0]         thr_sq_q;
  logic [65:0]         rad_q;
  logic [66:0]         root_q;
  logic [65:0]         bit_q;
  logic [49:0]         drem_q;
  logic [49:0]         dsh_q;
  logic [16:0]         quo_q;
  logic [16:0]         hw_q;
  logic [16:0]         wt_q;
  logic                out_vld_q;
  nea_pkg::out_entry_t out_q;
  logic signed [63:0]  acc_mem [nea_pkg::NumEntries];
  logic [nea_pkg::NumEntries-1:0] acc_vld_q;

  logic signed [32:0]  mul_a;
  logic signed [32:0]  mul_b;
  logic signed [65:0]  prod_d;
  logic signed [85:0]  scl_d;
  logic signed [85:0]  term_sh;
  logic signed [63:0]  term;
  logic signed [63:0]  acc_rd;
  logic signed [63:0]  acc_new;
  logic [4:0]          rd_addr;
  logic [4:0]          acc_addr;
  logic [66:0]         sq_try;
  logic                sq_ge;
  logic                dv_ge;
  logic [16:0]         quo_d;
  logic [33:0]         kw_prod;
  logic                huber_le;
  logic                item_done;
  logic                out_free;
  logic                out_load;
  logic                acc_we;

  // operand selection and products
  always_comb begin
    if (state_q == nea_pkg::ST_NORM) begin
      mul_a = nea_pkg::r_sel(step_q[1:0], head_i);
      mul_b = mul_a;
    end else begin
      mul_a = nea_pkg::jac_elem(step_q[1:0], col_i_q, head_i, JacOne);
      mul_b = (col_j_q == ColGrad) ? nea_pkg::r_sel(step_q[1:0], head_i) :
              nea_pkg::jac_elem(step_q[1:0], col_j_q, head_i, JacOne);
    end
    prod_d  = 66'(mul_a) * 66'(mul_b);
    scl_d   = 86'(sum_q) * $signed({69'b0, wt_q});
    term_sh = scl_q >>> OutShift;
    term    = nea_pkg::sat64(term_sh);
    acc_addr = (col_j_q == ColGrad) ? GradBase + 5'(col_i_q) : hidx_q;
    rd_addr  = (state_q == nea_pkg::ST_EMIT) ? em_q : acc_addr;
    acc_rd   = acc_vld_q[rd_addr] ? acc_mem[rd_addr] : '0;
    acc_new  = nea_pkg::sat64(86'(acc_rd) + 86'(term));
    sq_try   = root_q + 67'(bit_q);
    sq_ge    = 67'(rad_q) >= sq_try;
    dv_ge    = drem_q >= dsh_q;
    quo_d    = {quo_q[15:0], dv_ge};
    kw_prod  = hw_q * head_i.kind_w;
    huber_le = sum_q[65:0] <= 66'(thr_sq_q);
    item_done = (step_q == StepAcc) && (col_j_q == ColGrad) && (col_i_q == ColLast);
    out_free = !out_vld_q || pop_i;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nea_pkg::ST_IDLE:   if (head_valid_i) state_d = nea_pkg::ST_NORM;
      nea_pkg::ST_NORM:   if (step_q == StepSum) state_d = nea_pkg::ST_HUBER;
      nea_pkg::ST_HUBER:  state_d = huber_le ? nea_pkg::ST_WEIGHT : nea_pkg::ST_SQRT;
      nea_pkg::ST_SQRT:   if (bit_q[0]) state_d = nea_pkg::ST_DIV;
      nea_pkg::ST_DIV:    if (dcnt_q == 5'd0) state_d = nea_pkg::ST_WEIGHT;
      nea_pkg::ST_WEIGHT: state_d = nea_pkg::ST_ENTRY;
      nea_pkg::ST_ENTRY: begin
        if (item_done) state_d = head_i.last ? nea_pkg::ST_EMIT : nea_pkg::ST_IDLE;
      end
      nea_pkg::ST_EMIT: begin
        if (out_free && em_q == nea_pkg::LastEntryIdx) state_d = nea_pkg::ST_IDLE;
      end
      default: state_d = nea_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    out_load   = (state_q == nea_pkg::ST_EMIT) && out_free;
    acc_we     = (state_q == nea_pkg::ST_ENTRY) && (step_q == StepAcc);
    head_pop_o = ((state_q == nea_pkg::ST_ENTRY) && item_done && !head_i.last) ||
                 (out_load && em_q == nea_pkg::LastEntryIdx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nea_pkg::ST_IDLE;
      step_q    <= '0;
      col_i_q   <= '0;
      col_j_q   <= '0;
      hidx_q    <= '0;
      em_q      <= '0;
      dcnt_q    <= '0;
      out_vld_q <= 1'b0;
      acc_vld_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        nea_pkg::ST_IDLE: step_q <= '0;
        nea_pkg::ST_NORM: step_q <= step_q + 3'd1;
        nea_pkg::ST_SQRT: dcnt_q <= DivInit;
        nea_pkg::ST_DIV:  dcnt_q <= dcnt_q - 5'd1;
        nea_pkg::ST_WEIGHT: begin
          step_q  <= '0;
          col_i_q <= '0;
          col_j_q <= '0;
          hidx_q  <= '0;
          em_q    <= '0;
        end
        nea_pkg::ST_ENTRY: begin
          if (step_q == StepAcc) begin
            step_q <= '0;
            acc_vld_q[acc_addr] <= 1'b1;
            if (col_j_q == ColGrad) begin
              col_i_q <= col_i_q + 3'd1;
              col_j_q <= col_i_q + 3'd1;
            end else begin
              col_j_q <= (col_j_q == ColLast) ? ColGrad : col_j_q + 3'd1;
              hidx_q  <= hidx_q + 5'd1;
            end
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        nea_pkg::ST_EMIT: begin
          if (out_load) begin
            acc_vld_q[em_q] <= 1'b0;
            em_q <= em_q + 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    thr_sq_q <= thr_i * thr_i;
    prod_q   <= prod_d;
    if (step_q == 3'd0) begin
      sum_q <= '0;
    end else if (step_q <= StepSum) begin
      sum_q <= sum_q + 68'(prod_q);
    end
    if (step_q == StepScl) begin
      scl_q <= scl_d;
    end
    if (acc_we) begin
      acc_mem[acc_addr] <= acc_new;
    end
    if (out_load) begin
      out_q.entry_index <= em_q;
      out_q.entry_value <= acc_rd;
      out_q.last_entry  <= (em_q == nea_pkg::LastEntryIdx);
    end
    if (state_q == nea_pkg::ST_HUBER) begin
      hw_q   <= nea_pkg::OneQ16;
      rad_q  <= sum_q[65:0];
      root_q <= '0;
      bit_q  <= 66'(1) << 64;
    end
    if (state_q == nea_pkg::ST_SQRT) begin
      if (sq_ge) begin
        rad_q  <= 66'(67'(rad_q) - sq_try);
        root_q <= (root_q >> 1) + 67'(bit_q);
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (state_q == nea_pkg::ST_DIV) begin
      if (dcnt_q == DivInit) begin
        drem_q <= {2'b0, thr_i, 16'b0};
        dsh_q  <= {root_q[33:0], 16'b0};
        quo_q  <= '0;
      end else begin
        if (dv_ge) begin
          drem_q <= drem_q - dsh_q;
        end
        dsh_q <= dsh_q >> 1;
        quo_q <= quo_d;
        if (dcnt_q == 5'd0) begin
          hw_q <= (quo_d > nea_pkg::OneQ16) ? nea_pkg::OneQ16 : quo_d;
        end
      end
    end
    if (state_q == nea_pkg::ST_WEIGHT) begin
      wt_q <= kw_prod[32:16];
    end
  end

  assign empty_o = !out_vld_q;
  assign entry_o = out_q;

endmodule

// ===== rtl/icp_normal_equation_accumulator.sv =====
// ----------------------------------------------------------------------------
// icp_normal_equation_accumulator
// huber-weighted point-to-point icp normal equation accumulator
// ----------------------------------------------------------------------------
// For each item the squared residual norm is compared with the squared huber
// threshold; when it lies outside, a 33-step square root and a 17-step divide
// form the clipped weight. The item's 27 entries are then accumulated in turn
// on the shared 33x33 multiplier. An item marked last then emits
// its 27 sums at one per cycle while the result side takes them. The input
// queue holds two items, so pairs can be pushed while one is being worked.
`timescale 1ns / 1ps

module icp_normal_equation_accumulator #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  nea_pkg::in_pair_t   in_pair_i,
  output logic                empty,
  input  logic                pop,
  output nea_pkg::out_entry_t out_entry_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [16:0]         lambda_q;
  logic [31:0]         thr_q;
  logic                cfg_we;
  nea_pkg::reg_idx_e   reg_idx;
  logic                head_valid;
  logic                head_pop;
  nea_pkg::pair_work_t head;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = nea_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    unique case (reg_idx)
      nea_pkg::REG_LAMBDA:    prdata = {15'b0, lambda_q};
      nea_pkg::REG_THRESHOLD: prdata = thr_q;
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_q <= 17'd32768;
      thr_q    <= 32'd65536;
    end else if (cfg_we) begin
      unique case (reg_idx)
        nea_pkg::REG_LAMBDA:    lambda_q <= pwdata[16:0];
        nea_pkg::REG_THRESHOLD: thr_q    <= pwdata;
        default: ;
      endcase
    end
  end

  nea_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pair_i       (in_pair_i),
    .full_o       (full),
    .lambda_i     (lambda_q),
    .head_valid_o (head_valid),
    .head_o       (head),
    .head_pop_i   (head_pop)
  );

  nea_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .thr_i        (thr_q),
    .pop_i        (pop),
    .empty_o      (empty),
    .entry_o      (out_entry_o)
  );

endmodule

// ===== rtl/nea_checker.sv =====
// ----------------------------------------------------------------------------
// nea_checker
// port-level checks of the accumulator result stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "icp_normal_equation_accumulator_defines.svh"

module nea_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input logic                pready,
  input nea_pkg::out_entry_t out_entry_o
);

  `NEA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_entry_o))
  `NEA_ASSERT_IMP(a_idx_range, clk_i, rst_ni, !empty, out_entry_o.entry_index <= nea_pkg::LastEntryIdx)
  `NEA_ASSERT_IMP(a_last_tag, clk_i, rst_ni, !empty, out_entry_o.last_entry == (out_entry_o.entry_index == nea_pkg::LastEntryIdx))
  `NEA_ASSERT_NXT(a_idx_seq, clk_i, rst_ni, pop && !empty && !out_entry_o.last_entry, empty || out_entry_o.entry_index == $past(out_entry_o.entry_index) + 5'd1)
  `NEA_ASSERT_IMP(a_ready, clk_i, rst_ni, 1'b1, pready)

endmodule

bind icp_normal_equation_accumulator nea_checker u_nea_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .pready      (pready),
  .out_entry_o (out_entry_o)
);
